>>> sv/imu_bcs_pkg.sv
`default_nettype none

package imu_bcs_pkg;

   // Frame geometry: three accelerometer axes followed by three gyro axes.
   localparam int unsigned NUM_AXES       = 6;
   localparam int unsigned NUM_ACCEL_AXES = 3;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned OUT_W    = 32;
   localparam int unsigned SCALE_W  = 32;
   localparam int unsigned BAND_W   = 31;
   localparam int unsigned SUM_W    = 27;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // Magnitude of a calibration sum (at most 2^25 for up to 1024 samples),
   // and the width of the reciprocal used to divide it by the sample count.
   localparam int unsigned DIV_MAG_W = 26;
   localparam int unsigned DIV_MUL_W = 28;

   localparam int unsigned DEF_CALIB_SAMPLES = 100;
   localparam int unsigned DEF_FIFO_DEPTH    = 4;

   localparam logic [SCALE_W-1:0] SCALE_RST = 32'd1024;
   localparam logic [BAND_W-1:0]  BAND_RST  = 31'd0;

   typedef enum logic [1:0] {
      MODE_CONVERT = 2'd0,
      MODE_BEGIN   = 2'd1,
      MODE_SAMPLE  = 2'd2,
      MODE_LOAD    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_SCALE     = 2'd0,
      CSR_GYRO_SCALE      = 2'd1,
      CSR_ACCEL_DEAD_BAND = 2'd2,
      CSR_GYRO_DEAD_BAND  = 2'd3
   } csr_index_type;

   // Per-cycle commands from the controller to every lane.
   typedef struct packed {
      logic clear;
      logic load;
      logic accum;
      logic div_mul;
      logic div_write;
   } lane_ctrl_type;

   // Item flags that travel down the pipeline alongside the lane data.
   typedef struct packed {
      logic valid;
      logic conv;
      logic done;
      logic calibrating;
   } flags_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][OUT_W-1:0] axes;
      logic                           calib_done;
      logic                           calibrating;
   } result_type;

endpackage

`default_nettype wire

>>> sv/imu_bcs_req_if.sv
`default_nettype none

interface imu_bcs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;

   modport source (
      output valid, mode, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      input  ready
   );

   modport sink (
      input  valid, mode, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/imu_bcs_rsp_if.sv
`default_nettype none

interface imu_bcs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_x_out;
   logic signed [31:0] accel_y_out;
   logic signed [31:0] accel_z_out;
   logic signed [31:0] rate_x_out;
   logic signed [31:0] rate_y_out;
   logic signed [31:0] rate_z_out;
   logic               calib_done;
   logic               calibrating;

   modport source (
      output valid, accel_x_out, accel_y_out, accel_z_out,
             rate_x_out, rate_y_out, rate_z_out, calib_done, calibrating,
      input  ready
   );

   modport sink (
      input  valid, accel_x_out, accel_y_out, accel_z_out,
             rate_x_out, rate_y_out, rate_z_out, calib_done, calibrating,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/imu_bcs_lane.sv
`default_nettype none

module imu_bcs_lane #(
   parameter int unsigned CALIB_SAMPLES = imu_bcs_pkg::DEF_CALIB_SAMPLES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire imu_bcs_pkg::lane_ctrl_type            lane_ctrl,
   input  wire logic signed [imu_bcs_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [imu_bcs_pkg::SCALE_W-1:0]       scale,
   input  wire logic [imu_bcs_pkg::BAND_W-1:0]        dead_band,
   output logic signed [imu_bcs_pkg::OUT_W-1:0]       result
);

   localparam int unsigned MAG_W   = imu_bcs_pkg::DIV_MAG_W;
   localparam int unsigned MUL_W   = imu_bcs_pkg::DIV_MUL_W;
   localparam int unsigned DPROD_W = MAG_W + MUL_W;
   // Exact floor division of any value below 2^MAG_W by a constant:
   // multiply by ceil(2^k / N) with k = MAG_W + ceil(log2 N), then shift by k.
   localparam int unsigned DIV_SHIFT = MAG_W + $clog2(CALIB_SAMPLES);
   localparam logic [63:0] DIV_MUL_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
   localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_FULL);

   localparam int unsigned ADD_W  = imu_bcs_pkg::SAMPLE_W + 1;
   localparam int unsigned PROD_W = ADD_W + imu_bcs_pkg::SCALE_W + 1;
   localparam int unsigned Q_W    = PROD_W - 8;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(64'sd2147483647);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-64'sd2147483648);

   logic signed [imu_bcs_pkg::SAMPLE_W-1:0] offset_ff, offset_in;
   logic signed [imu_bcs_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic signed [ADD_W-1:0]                 add_ff;
   logic signed [PROD_W-1:0]                prod_ff;
   logic [DPROD_W-1:0]                      div_prod_ff;
   logic                                    div_neg_ff;

   logic [MAG_W-1:0]                        sum_mag;
   logic [MAG_W-1:0]                        quot;
   logic signed [imu_bcs_pkg::SAMPLE_W-1:0] mean;
   logic signed [Q_W-1:0]                   shifted;
   logic signed [imu_bcs_pkg::OUT_W-1:0]    sat;
   logic signed [imu_bcs_pkg::OUT_W:0]      sat_ext;
   logic [imu_bcs_pkg::OUT_W:0]             out_mag;

   // Calibration mean: magnitude times reciprocal, then sign and clamp.
   always_comb begin
      sum_mag = sum_ff[imu_bcs_pkg::SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      quot    = MAG_W'(div_prod_ff >> DIV_SHIFT);
      if (!div_neg_ff) begin
         mean = (quot > MAG_W'(32767)) ? 16'sh7fff : signed'(quot[15:0]);
      end else begin
         mean = (quot >= MAG_W'(32768)) ? 16'sh8000 : signed'(16'd0 - quot[15:0]);
      end
   end

   always_comb begin
      offset_in = offset_ff;
      sum_in    = sum_ff;
      priority if (lane_ctrl.clear) begin
         offset_in = '0;
         sum_in    = '0;
      end else if (lane_ctrl.load) begin
         offset_in = sample;
      end else if (lane_ctrl.accum) begin
         sum_in = sum_ff - imu_bcs_pkg::SUM_W'(sample);
      end else if (lane_ctrl.div_write) begin
         offset_in = mean;
      end else begin
         offset_in = offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sum_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

   // The scaling registers load every cycle; the controller tracks which hold
   // items. The divide product is taken only in its multiply cycle.
   always_ff @(posedge clock) begin
      add_ff  <= ADD_W'(sample) + ADD_W'(offset_ff);
      prod_ff <= add_ff * $signed({1'b0, scale});
      if (lane_ctrl.div_mul) begin
         div_prod_ff <= DPROD_W'(sum_mag) * DPROD_W'(DIV_MUL);
         div_neg_ff  <= sum_ff[imu_bcs_pkg::SUM_W-1];
      end
   end

   // Q8.24 product to Q16.16 with floor shift, saturation and dead band.
   always_comb begin
      shifted = Q_W'(prod_ff >>> 8);
      if (shifted > Q_MAX) begin
         sat = 32'sh7fffffff;
      end else if (shifted < Q_MIN) begin
         sat = 32'sh80000000;
      end else begin
         sat = imu_bcs_pkg::OUT_W'(shifted);
      end
      sat_ext = (imu_bcs_pkg::OUT_W + 1)'(sat);
      out_mag = sat_ext[imu_bcs_pkg::OUT_W] ? unsigned'(-sat_ext) : unsigned'(sat_ext);
      result  = (out_mag < {2'b00, dead_band}) ? '0 : sat;
   end

endmodule

`default_nettype wire

>>> sv/imu_bcs_ctrl.sv
`default_nettype none

module imu_bcs_ctrl #(
   parameter int unsigned CALIB_SAMPLES = imu_bcs_pkg::DEF_CALIB_SAMPLES,
   parameter int unsigned FIFO_DEPTH    = imu_bcs_pkg::DEF_FIFO_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire imu_bcs_pkg::mode_type      req_mode,
   input  wire logic                       pop,
   output logic                            req_ready,
   output imu_bcs_pkg::lane_ctrl_type      lane_ctrl,
   output imu_bcs_pkg::flags_type          flags2
);

   localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
   localparam int unsigned INF_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(CALIB_SAMPLES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   active_ff, active_in;
   logic [INF_W-1:0]       inflight_ff, inflight_in;
   imu_bcs_pkg::flags_type flags1_ff, flags1_in;
   imu_bcs_pkg::flags_type flags2_ff;
   logic                   accept;
   logic                   done;
   logic                   conv;

   assign req_ready = (state_ff == ST_IDLE) && (inflight_ff < INF_W'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;
   assign flags2    = flags2_ff;

   always_comb begin
      lane_ctrl           = '0;
      lane_ctrl.div_mul   = (state_ff == ST_MUL);
      lane_ctrl.div_write = (state_ff == ST_WRITE);
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done      = 1'b0;
      conv      = 1'b0;

      unique case (state_ff)
         ST_IDLE:  state_in = ST_IDLE;
         ST_MUL:   state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase

      if (accept) begin
         unique case (req_mode)
            imu_bcs_pkg::MODE_CONVERT: begin
               conv = 1'b1;
            end
            imu_bcs_pkg::MODE_BEGIN: begin
               lane_ctrl.clear = 1'b1;
               cnt_in    = '0;
               active_in = 1'b1;
            end
            imu_bcs_pkg::MODE_SAMPLE: begin
               // A sample with no calibration running is not accumulated.
               if (active_ff) begin
                  lane_ctrl.accum = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff == LAST_SAMPLE) begin
                     active_in = 1'b0;
                     done      = 1'b1;
                     state_in  = ST_MUL;
                  end
               end
            end
            imu_bcs_pkg::MODE_LOAD: begin
               lane_ctrl.load = 1'b1;
               active_in      = 1'b0;
            end
            default: begin
               conv = 1'b0;
            end
         endcase
      end

      flags1_in.valid       = accept;
      flags1_in.conv        = conv;
      flags1_in.done        = done;
      flags1_in.calibrating = active_in;
      inflight_in = inflight_ff + INF_W'(accept) - INF_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         active_ff   <= 1'b0;
         inflight_ff <= '0;
         flags1_ff   <= '0;
         flags2_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         active_ff   <= active_in;
         inflight_ff <= inflight_in;
         flags1_ff   <= flags1_in;
         flags2_ff   <= flags1_ff;
      end
   end

endmodule

`default_nettype wire

>>> sv/imu_bcs_merge.sv
`default_nettype none

module imu_bcs_merge #(
   parameter int unsigned DEPTH = imu_bcs_pkg::DEF_FIFO_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire imu_bcs_pkg::flags_type  flags,
   input  wire logic [imu_bcs_pkg::NUM_AXES-1:0][imu_bcs_pkg::OUT_W-1:0] lane_res,
   input  wire logic                    pop,
   output imu_bcs_pkg::result_type      head,
   output logic                         head_valid
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   imu_bcs_pkg::result_type mem_ff [DEPTH];
   imu_bcs_pkg::result_type entry;
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;

   // Lanes only carry meaning on convert items; every other beat is zero.
   always_comb begin
      for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++) begin
         entry.axes[i] = flags.conv ? lane_res[i] : '0;
      end
      entry.calib_done  = flags.done;
      entry.calibrating = flags.calibrating;
   end

   always_ff @(posedge clock) begin
      if (flags.valid) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (flags.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(flags.valid) - CNT_W'(pop);
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

endmodule

`default_nettype wire

>>> sv/imu_bias_calibrate_and_scale_unit.sv
// Six-axis IMU offset calibration and Q16.16 scaling.
// Input beats arrive on req_ch (mode plus three accelerations and three
// rotation rates); every accepted beat produces exactly one result beat on
// rsp_ch, in order. Convert beats add the stored offset per axis, scale by
// the accel or gyro Q8.24 factor, saturate and apply the dead band; other
// modes return zero axes with the calibration flags.
// An accepted beat passes its lane's add and product registers into the
// result queue. Throughput is one beat per cycle while the receiver keeps
// up: six parallel lanes do the per-axis work and a four-entry result queue
// absorbs the pipeline. The only gap is after the sample that completes a
// calibration: ready drops while each lane multiplies its sum by the
// reciprocal of the sample count and writes the new offset.
// When the receiver stalls, results collect in the queue and ready falls
// once four beats are outstanding, so nothing is lost or overwritten.
// Reset (synchronous, active high) clears offsets, sums, the sample count,
// the calibration state and the queue, and restores the register defaults.
// Registers are written through csr_* in a single cycle; write them only while idle, as the block does not enforce it.
`default_nettype none

module imu_bias_calibrate_and_scale_unit #(
   parameter int unsigned CALIB_SAMPLES = imu_bcs_pkg::DEF_CALIB_SAMPLES,
   parameter int unsigned FIFO_DEPTH    = imu_bcs_pkg::DEF_FIFO_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   imu_bcs_req_if.sink                              req_ch,
   imu_bcs_rsp_if.source                            rsp_ch,
   input  wire logic                                csr_write_enable,
   input  wire logic [imu_bcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [imu_bcs_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [imu_bcs_pkg::SCALE_W-1:0] accel_scale_ff, gyro_scale_ff;
   logic [imu_bcs_pkg::BAND_W-1:0]  accel_band_ff, gyro_band_ff;

   logic signed [imu_bcs_pkg::SAMPLE_W-1:0] samples [imu_bcs_pkg::NUM_AXES];
   logic [imu_bcs_pkg::NUM_AXES-1:0][imu_bcs_pkg::OUT_W-1:0] lane_res;

   imu_bcs_pkg::lane_ctrl_type lane_ctrl;
   imu_bcs_pkg::flags_type     flags2;
   imu_bcs_pkg::result_type    head;
   logic                       head_valid;
   logic                       pop;
   logic                       ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_scale_ff <= imu_bcs_pkg::SCALE_RST;
         gyro_scale_ff  <= imu_bcs_pkg::SCALE_RST;
         accel_band_ff  <= imu_bcs_pkg::BAND_RST;
         gyro_band_ff   <= imu_bcs_pkg::BAND_RST;
      end else if (csr_write_enable) begin
         unique case (imu_bcs_pkg::csr_index_type'(csr_index))
            imu_bcs_pkg::CSR_ACCEL_SCALE:
               accel_scale_ff <= csr_write_data;
            imu_bcs_pkg::CSR_GYRO_SCALE:
               gyro_scale_ff <= csr_write_data;
            imu_bcs_pkg::CSR_ACCEL_DEAD_BAND:
               accel_band_ff <= csr_write_data[imu_bcs_pkg::BAND_W-1:0];
            imu_bcs_pkg::CSR_GYRO_DEAD_BAND:
               gyro_band_ff <= csr_write_data[imu_bcs_pkg::BAND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign samples[0] = req_ch.accel_x;
   assign samples[1] = req_ch.accel_y;
   assign samples[2] = req_ch.accel_z;
   assign samples[3] = req_ch.rate_x;
   assign samples[4] = req_ch.rate_y;
   assign samples[5] = req_ch.rate_z;

   // The controller decodes the mode, owns the calibration count and
   // sequences the divide (multiply, then offset write) at the end of a calibration.
   imu_bcs_ctrl #(
      .CALIB_SAMPLES (CALIB_SAMPLES),
      .FIFO_DEPTH    (FIFO_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (imu_bcs_pkg::mode_type'(req_ch.mode)),
      .pop       (pop),
      .req_ready (ready),
      .lane_ctrl (lane_ctrl),
      .flags2    (flags2)
   );

   assign req_ch.ready = ready;

   // One lane per axis; the first three use the accelerometer settings.
   for (genvar g = 0; g < imu_bcs_pkg::NUM_AXES; g++) begin : g_lane
      imu_bcs_lane #(
         .CALIB_SAMPLES (CALIB_SAMPLES)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .lane_ctrl (lane_ctrl),
         .sample    (samples[g]),
         .scale     ((g < imu_bcs_pkg::NUM_ACCEL_AXES) ? accel_scale_ff : gyro_scale_ff),
         .dead_band ((g < imu_bcs_pkg::NUM_ACCEL_AXES) ? accel_band_ff : gyro_band_ff),
         .result    (lane_res[g])
      );
   end

   // The merge stage assembles the lane results and flags into one beat and
   // queues it towards the output.
   imu_bcs_merge #(
      .DEPTH (FIFO_DEPTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .flags      (flags2),
      .lane_res   (lane_res),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   assign pop = head_valid && rsp_ch.ready;

   assign rsp_ch.valid       = head_valid;
   assign rsp_ch.accel_x_out = signed'(head.axes[0]);
   assign rsp_ch.accel_y_out = signed'(head.axes[1]);
   assign rsp_ch.accel_z_out = signed'(head.axes[2]);
   assign rsp_ch.rate_x_out  = signed'(head.axes[3]);
   assign rsp_ch.rate_y_out  = signed'(head.axes[4]);
   assign rsp_ch.rate_z_out  = signed'(head.axes[5]);
   assign rsp_ch.calib_done  = head.calib_done;
   assign rsp_ch.calibrating = head.calibrating;

   // The divide multiply is always followed by the offset write.
   assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.div_mul |=> lane_ctrl.div_write)
      else $error("offset write did not follow the divide multiply");

   // No beat may be taken while the offsets are being recomputed.
   assert property (@(posedge clock) disable iff (reset)
      (lane_ctrl.div_mul || lane_ctrl.div_write) |-> !req_ch.ready)
      else $error("input accepted during the offset divide");

   // A completed calibration reaches the second stage as its offsets are written.
   assert property (@(posedge clock) disable iff (reset)
      (flags2.valid && flags2.done) |-> lane_ctrl.div_write)
      else $error("calibration finished without writing the offsets");

   // A finishing beat is never a convert beat and leaves calibration off.
   assert property (@(posedge clock) disable iff (reset)
      (flags2.valid && flags2.done) |-> (!flags2.conv && !flags2.calibrating))
      else $error("inconsistent flags on the calibration done beat");

endmodule

`default_nettype wire

>>> tb/tb_imu_bias_calibrate_and_scale_unit.sv
`timescale 1ns / 100ps

// Self-checking bench for the IMU offset calibration and scaling unit.
// Every accepted request beat is run through a behavioural model of the
// unit. The model keeps its own offsets, calibration sums and register copies,
// and the result it works out is queued. Each result beat that the unit hands
// over is compared field by field with the oldest queued result.
module tb_imu_bias_calibrate_and_scale_unit;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 9;
   localparam int FRAMES_PER_CALIB = imu_bcs_pkg::DEF_CALIB_SAMPLES;
   localparam int RANDOM_FRAMES    = 300;
   localparam int FRAMES_PER_PHASE = 100;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT      = 100000;
   localparam int REPORT_LIMIT     = 10;

   // One request beat: the mode and six raw samples, accelerations first.
   typedef struct packed {
      imu_bcs_pkg::mode_type mode;
      logic [5:0][15:0]      axis;
   } imu_frame_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_write_enable;
   imu_bcs_pkg::csr_index_type         csr_index;
   logic [imu_bcs_pkg::CSR_DATA_W-1:0] csr_write_data;

   imu_bcs_req_if req_ch ();
   imu_bcs_rsp_if rsp_ch ();

   imu_bias_calibrate_and_scale_unit #(
      .CALIB_SAMPLES(FRAMES_PER_CALIB)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Model copies of the registers and of the unit's state.
   logic [31:0]        accel_gain;
   logic [31:0]        gyro_gain;
   logic [30:0]        accel_band;
   logic [30:0]        gyro_band;
   logic signed [15:0] axis_offset [imu_bcs_pkg::NUM_AXES];
   logic signed [26:0] calib_sum [imu_bcs_pkg::NUM_AXES];
   logic [10:0]        calib_count;
   logic               calib_active;

   // Results still owed by the unit, oldest first.
   imu_bcs_pkg::result_type pending_results [$];

   string axis_label [imu_bcs_pkg::NUM_AXES] = '{"accel_x_out", "accel_y_out",
                                                 "accel_z_out", "rate_x_out",
                                                 "rate_y_out", "rate_z_out"};

   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   int rsp_wait_left = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int fault_count   = 0;
   int cycle_count   = 0;
   int frames_accepted = 0;

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Behavioural model
   // ---------------------------------------------------------------------

   // Offset add, Q8.24 multiply, shift to Q16.16 with rounding towards minus
   // infinity, saturation to 32 bits, and finally the dead band. The
   // magnitude is kept wide, so the most negative value counts as 2^31.
   function automatic logic [31:0] scale_axis(logic signed [15:0] raw,
                                              logic signed [15:0] off,
                                              logic [31:0] gain, logic [30:0] band);
      longint total;
      longint factor;
      longint limit;
      longint scaled;
      longint mag;
      total  = raw;
      total  = total + off;
      factor = gain;
      limit  = band;
      scaled = (total * factor) >>> 8;
      if (scaled > 64'sd2147483647)
         scaled = 64'sd2147483647;
      if (scaled < -64'sd2147483648)
         scaled = -64'sd2147483648;
      mag = (scaled < 0) ? -scaled : scaled;
      if (mag < limit)
         scaled = 0;
      return scaled[31:0];
   endfunction

   function automatic imu_bcs_pkg::result_type predict_frame_result(imu_frame_type f);
      imu_bcs_pkg::result_type r;
      int                      sum_value;
      int                      mean;
      r = '0;
      case (f.mode)
         imu_bcs_pkg::MODE_CONVERT: begin
            for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++) begin
               if (i < imu_bcs_pkg::NUM_ACCEL_AXES)
                  r.axes[i] = scale_axis(f.axis[i], axis_offset[i], accel_gain, accel_band);
               else
                  r.axes[i] = scale_axis(f.axis[i], axis_offset[i], gyro_gain, gyro_band);
            end
         end
         imu_bcs_pkg::MODE_BEGIN: begin
            // A begin always restarts from scratch, even mid-calibration.
            for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++) begin
               axis_offset[i] = '0;
               calib_sum[i]   = '0;
            end
            calib_count  = '0;
            calib_active = 1'b1;
         end
         imu_bcs_pkg::MODE_SAMPLE: begin
            // Samples with no calibration running leave everything alone.
            if (calib_active) begin
               for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
                  calib_sum[i] = calib_sum[i] - $signed(f.axis[i]);
               calib_count++;
               if (calib_count >= FRAMES_PER_CALIB) begin
                  for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++) begin
                     sum_value = calib_sum[i];
                     mean = sum_value / FRAMES_PER_CALIB;
                     // Only a mean of +32768 can fall outside the offset range.
                     if (mean > 32767)
                        mean = 32767;
                     if (mean < -32768)
                        mean = -32768;
                     axis_offset[i] = 16'(mean);
                  end
                  calib_active = 1'b0;
                  r.calib_done = 1'b1;
               end
            end
         end
         imu_bcs_pkg::MODE_LOAD: begin
            // Loading offsets also abandons any calibration in progress.
            for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
               axis_offset[i] = f.axis[i];
            calib_active = 1'b0;
         end
      endcase
      r.calibrating = calib_active;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Raw sample generator weighted towards the range ends and small values.
   function automatic logic [15:0] random_sample();
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1, 2:    v = 16'($urandom_range(0, 510)) - 16'd255;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic imu_frame_type make_frame(imu_bcs_pkg::mode_type m);
      imu_frame_type f;
      f.mode = m;
      for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
         f.axis[i] = random_sample();
      return f;
   endfunction

   // All accelerations take one value and all rates another.
   function automatic imu_frame_type uniform_frame(imu_bcs_pkg::mode_type m,
                                                   logic [15:0] accel,
                                                   logic [15:0] rate);
      imu_frame_type f;
      f.mode = m;
      for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
         f.axis[i] = (i < imu_bcs_pkg::NUM_ACCEL_AXES) ? accel : rate;
      return f;
   endfunction

   function automatic logic [31:0] pick_gain();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = '1;
         2:       v = imu_bcs_pkg::SCALE_RST;
         3:       v = 32'h0100_0000;
         4:       v = $urandom_range(0, 32'h0400_0000);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Bit 31 is driven too; the unit is expected to drop it.
   function automatic logic [31:0] pick_band();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0:       v = '0;
         1:       v = '1;
         2:       v = $urandom_range(0, 32'h0010_0000);
         3:       v = $urandom_range(0, 32'h1000_0000);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Offers one request beat, after a random gap while sender_idle is set,
   // and waits for it to be taken. The model is stepped at the acceptance edge.
   task automatic send_frame(imu_frame_type f);
      int gap;
      gap = sender_idle ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= f.mode;
      req_ch.accel_x <= f.axis[0];
      req_ch.accel_y <= f.axis[1];
      req_ch.accel_z <= f.axis[2];
      req_ch.rate_x  <= f.axis[3];
      req_ch.rate_y  <= f.axis[4];
      req_ch.rate_z  <= f.axis[5];
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      // Samples arriving outside a calibration change no state and are not counted.
      if (f.mode != imu_bcs_pkg::MODE_SAMPLE || calib_active)
         frames_accepted++;
      pending_results.push_back(predict_frame_result(f));
   endtask

   // Stops offering beats, waits for every owed result, then lets the unit
   // finish any offset write-back that trails the last result.
   task automatic wait_until_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Single-cycle register write; only ever called with the unit idle.
   task automatic write_register(imu_bcs_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         imu_bcs_pkg::CSR_ACCEL_SCALE:     accel_gain = value;
         imu_bcs_pkg::CSR_GYRO_SCALE:      gyro_gain  = value;
         imu_bcs_pkg::CSR_ACCEL_DEAD_BAND: accel_band = value[30:0];
         imu_bcs_pkg::CSR_GYRO_DEAD_BAND:  gyro_band  = value[30:0];
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   function automatic void flag_fault(string what, longint want, longint got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
   endfunction

   // Each handshake is checked against the oldest owed result, and the
   // stall before the next beat is drawn here.
   always @(posedge clock) begin
      imu_bcs_pkg::result_type want;
      imu_bcs_pkg::result_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.axes[0]     = rsp_ch.accel_x_out;
         got.axes[1]     = rsp_ch.accel_y_out;
         got.axes[2]     = rsp_ch.accel_z_out;
         got.axes[3]     = rsp_ch.rate_x_out;
         got.axes[4]     = rsp_ch.rate_y_out;
         got.axes[5]     = rsp_ch.rate_z_out;
         got.calib_done  = rsp_ch.calib_done;
         got.calibrating = rsp_ch.calibrating;
         if (pending_results.size() == 0) begin
            flag_fault("result beats outstanding", 0, 1);
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
               if (got.axes[i] !== want.axes[i])
                  flag_fault(axis_label[i], $signed(want.axes[i]), $signed(got.axes[i]));
            if (got.calib_done !== want.calib_done)
               flag_fault("calib_done", want.calib_done, got.calib_done);
            if (got.calibrating !== want.calibrating)
               flag_fault("calibrating", want.calibrating, got.calibrating);
         end
         rsp_wait_left = receiver_idle ? $urandom_range(0, 4) : 0;
      end
   end

   // Ready is driven on the falling edge. A long hold requested by a test
   // is counted down here and overrides the per-beat stall.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_wait_left > 0) begin
         rsp_wait_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset registers (scale 1024, no dead band) and zero offsets, with the
   // sample extremes and alternating bit patterns.
   task automatic test_reset_defaults();
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h7FFF, 16'h7FFF));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8000, 16'h8000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h0000, 16'h0000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h5555, 16'hAAAA));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'hAAAA, 16'h5555));
      wait_until_idle();
   endtask

   // Every mode, and each of them in the awkward places: a sample while no
   // calibration runs, a convert during a calibration, a begin that restarts
   // one, and a load that aborts one.
   task automatic test_mode_sequences();
      send_frame(uniform_frame(imu_bcs_pkg::MODE_LOAD, 16'h7FFF, 16'h8000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h7FFF, 16'h8000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8000, 16'h7FFF));
      send_frame(make_frame(imu_bcs_pkg::MODE_SAMPLE));
      send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
      send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
      send_frame(make_frame(imu_bcs_pkg::MODE_SAMPLE));
      send_frame(make_frame(imu_bcs_pkg::MODE_SAMPLE));
      send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
      send_frame(make_frame(imu_bcs_pkg::MODE_SAMPLE));
      send_frame(make_frame(imu_bcs_pkg::MODE_LOAD));
      send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
      wait_until_idle();
   endtask

   // Full-scale gain drives both saturation limits. The odd gyro gain shows
   // the rounding of negative products towards minus infinity. The widest
   // dead band keeps both limits, since neither magnitude lies below it.
   task automatic test_saturation_and_dead_band();
      write_register(imu_bcs_pkg::CSR_ACCEL_SCALE, 32'hFFFF_FFFF);
      write_register(imu_bcs_pkg::CSR_GYRO_SCALE, 32'd383);
      send_frame(uniform_frame(imu_bcs_pkg::MODE_LOAD, 16'h7FFF, 16'h0000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h7FFF, 16'hFFFF));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_LOAD, 16'h8000, 16'h0000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8000, 16'h0001));
      wait_until_idle();
      write_register(imu_bcs_pkg::CSR_ACCEL_DEAD_BAND, 32'hFFFF_FFFF);
      write_register(imu_bcs_pkg::CSR_GYRO_DEAD_BAND, 32'd2);
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8000, 16'h0001));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_LOAD, 16'h7FFF, 16'h0000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h7FFF, 16'hFFFA));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8008, 16'hFFFE));
      wait_until_idle();
      write_register(imu_bcs_pkg::CSR_ACCEL_SCALE, 32'd0);
      write_register(imu_bcs_pkg::CSR_GYRO_SCALE, 32'd0);
      write_register(imu_bcs_pkg::CSR_ACCEL_DEAD_BAND, 32'd0);
      write_register(imu_bcs_pkg::CSR_GYRO_DEAD_BAND, 32'd0);
      send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
      wait_until_idle();
      write_register(imu_bcs_pkg::CSR_ACCEL_SCALE, 32'h0100_0000);
      write_register(imu_bcs_pkg::CSR_GYRO_SCALE, 32'h0100_0000);
   endtask

   // A full calibration on the most negative accelerations and the most
   // positive rates: the accel mean of +32768 must clip to an offset of
   // 32767, and the rate offsets come out at -32767.
   task automatic test_calibration_extremes();
      send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
      repeat (FRAMES_PER_CALIB)
         send_frame(uniform_frame(imu_bcs_pkg::MODE_SAMPLE, 16'h8000, 16'h7FFF));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h0000, 16'h0000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h7FFF, 16'h8000));
      send_frame(uniform_frame(imu_bcs_pkg::MODE_CONVERT, 16'h8000, 16'h7FFF));
      wait_until_idle();
   endtask

   // The receiver stops for a long stretch while the sender keeps beats
   // coming back to back, so the result queue fills and request ready has
   // to fall. The sender then pauses until everything has drained.
   task automatic test_backpressure();
      sender_idle  = 1'b0;
      hold_request = LONG_HOLD_CYCLES;
      repeat (24)
         send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
      wait_until_idle();
      sender_idle = 1'b1;
   endtask

   // A calibration run: samples scattered around a random centre per axis,
   // with the odd convert mixed in and, rarely, a restart. It runs until
   // the model sees the calibration complete, then uses the new offsets.
   task automatic run_calibration();
      logic [15:0]   centre [imu_bcs_pkg::NUM_AXES];
      logic [15:0]   spread;
      imu_frame_type f;
      for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
         centre[i] = random_sample();
      case ($urandom_range(0, 3))
         0:       spread = 16'd0;
         1:       spread = 16'd15;
         2:       spread = 16'd1023;
         default: spread = 16'd32767;
      endcase
      send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
      while (calib_active) begin
         if ($urandom_range(0, 19) == 0) begin
            send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
         end else if ($urandom_range(0, 299) == 0) begin
            send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
         end else begin
            f.mode = imu_bcs_pkg::MODE_SAMPLE;
            for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++)
               f.axis[i] = centre[i] + 16'($urandom_range(0, 2 * spread)) - spread;
            send_frame(f);
         end
      end
      repeat ($urandom_range(2, 6))
         send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
   endtask

   // Random phases, each under a fresh register setting and idling choice.
   // Most traffic is calibrations and convert bursts; the rest is broken
   // calibrations and beats of any mode.
   task automatic test_random_traffic();
      int phase;
      int phase_end;
      int start_count;
      int pick;
      phase       = 0;
      start_count = frames_accepted;
      while (frames_accepted - start_count < RANDOM_FRAMES) begin
         wait_until_idle();
         write_register(imu_bcs_pkg::CSR_ACCEL_SCALE, pick_gain());
         write_register(imu_bcs_pkg::CSR_GYRO_SCALE, pick_gain());
         write_register(imu_bcs_pkg::CSR_ACCEL_DEAD_BAND, pick_band());
         write_register(imu_bcs_pkg::CSR_GYRO_DEAD_BAND, pick_band());
         sender_idle   = (phase % 4 != 3);
         receiver_idle = (phase % 3 != 2);
         phase_end     = frames_accepted + FRAMES_PER_PHASE;
         while (frames_accepted < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               run_calibration();
            end else if (pick < 75) begin
               if ($urandom_range(0, 1))
                  send_frame(make_frame(imu_bcs_pkg::MODE_LOAD));
               repeat ($urandom_range(4, 16))
                  send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
            end else if (pick < 88) begin
               send_frame(make_frame(imu_bcs_pkg::MODE_BEGIN));
               repeat ($urandom_range(0, 10))
                  send_frame(make_frame(imu_bcs_pkg::MODE_SAMPLE));
               send_frame(make_frame($urandom_range(0, 1) ? imu_bcs_pkg::MODE_LOAD
                                                          : imu_bcs_pkg::MODE_BEGIN));
               repeat ($urandom_range(2, 5))
                  send_frame(make_frame(imu_bcs_pkg::MODE_CONVERT));
            end else begin
               repeat ($urandom_range(1, 8))
                  send_frame(make_frame(imu_bcs_pkg::mode_type'($urandom_range(0, 3))));
            end
         end
         phase++;
      end
      wait_until_idle();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = imu_bcs_pkg::CSR_ACCEL_SCALE;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = imu_bcs_pkg::MODE_CONVERT;
      req_ch.accel_x   = '0;
      req_ch.accel_y   = '0;
      req_ch.accel_z   = '0;
      req_ch.rate_x    = '0;
      req_ch.rate_y    = '0;
      req_ch.rate_z    = '0;

      // The model starts from the unit's reset state.
      accel_gain   = imu_bcs_pkg::SCALE_RST;
      gyro_gain    = imu_bcs_pkg::SCALE_RST;
      accel_band   = imu_bcs_pkg::BAND_RST;
      gyro_band    = imu_bcs_pkg::BAND_RST;
      calib_count  = '0;
      calib_active = 1'b0;
      for (int i = 0; i < imu_bcs_pkg::NUM_AXES; i++) begin
         axis_offset[i] = '0;
         calib_sum[i]   = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mode_sequences();
      test_saturation_and_dead_band();
      test_calibration_extremes();
      test_backpressure();
      test_random_traffic();

      wait_until_idle();
      if (fault_count == 0 && pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
sv/imu_bcs_pkg.sv
sv/imu_bcs_req_if.sv
sv/imu_bcs_rsp_if.sv
sv/imu_bcs_lane.sv
sv/imu_bcs_ctrl.sv
sv/imu_bcs_merge.sv
sv/imu_bias_calibrate_and_scale_unit.sv
tb/tb_imu_bias_calibrate_and_scale_unit.sv
